@@ design/sit_pkg.sv @@
`timescale 1ns / 1ps

package sit_pkg;

  // Width of every coordinate field on the ports.
  localparam int FIELD_WIDTH = 32;
  // Only the low COORD_WIDTH bits of a field are used; they are sign extended.
  localparam int COORD_WIDTH = 32;
  // A difference of two coordinates needs one more bit.
  localparam int DIFF_W      = COORD_WIDTH + 1;
  // The product of two differences.
  localparam int PROD_W      = 2 * DIFF_W;
  // The difference of two products.
  localparam int ORIENT_W    = PROD_W + 1;

  typedef logic signed [FIELD_WIDTH-1:0] field_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [ORIENT_W-1:0]    orient_t;

  // Bit k is set when the point of orientation k lies in the box of the other segment.
  typedef logic [3:0] box_t;

  typedef struct packed {
    diff_t bax;
    diff_t bay;
    diff_t cax;
    diff_t cay;
    diff_t dax;
    diff_t day;
    diff_t dcx;
    diff_t dcy;
    diff_t acx;
    diff_t acy;
    diff_t bcx;
    diff_t bcy;
    box_t  box;
  } diffs_t;

  typedef struct packed {
    prod_t u1;
    prod_t v1;
    prod_t u2;
    prod_t v2;
    prod_t u3;
    prod_t v3;
    prod_t u4;
    prod_t v4;
    box_t  box;
  } prods_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } osign_t;

  typedef struct packed {
    osign_t s1;
    osign_t s2;
    osign_t s3;
    osign_t s4;
    box_t   box;
  } signs_t;

  // Load enables of the two back stages.
  typedef struct packed {
    logic sub;
    logic fin;
  } back_en_t;

endpackage

@@ design/sit_if.sv @@
`timescale 1ns / 1ps

interface sit_in_if;
  logic            valid;
  logic            ready;
  sit_pkg::field_t a_x;
  sit_pkg::field_t a_y;
  sit_pkg::field_t b_x;
  sit_pkg::field_t b_y;
  sit_pkg::field_t c_x;
  sit_pkg::field_t c_y;
  sit_pkg::field_t d_x;
  sit_pkg::field_t d_y;

  modport source (output valid, output a_x, output a_y, output b_x, output b_y,
                  output c_x, output c_y, output d_x, output d_y, input ready);
  modport sink   (input valid, input a_x, input a_y, input b_x, input b_y,
                  input c_x, input c_y, input d_x, input d_y, output ready);
endinterface

interface sit_out_if;
  logic valid;
  logic ready;
  logic segments_meet;

  modport source (output valid, output segments_meet, input ready);
  modport sink   (input valid, input segments_meet, output ready);
endinterface

@@ design/sit_front.sv @@
`timescale 1ns / 1ps

module sit_front (
  input  logic             clk,
  input  logic             en,
  input  sit_pkg::field_t  a_x,
  input  sit_pkg::field_t  a_y,
  input  sit_pkg::field_t  b_x,
  input  sit_pkg::field_t  b_y,
  input  sit_pkg::field_t  c_x,
  input  sit_pkg::field_t  c_y,
  input  sit_pkg::field_t  d_x,
  input  sit_pkg::field_t  d_y,
  output sit_pkg::diffs_t  q_r
);

  function automatic sit_pkg::diff_t sext(input sit_pkg::field_t f);
    return sit_pkg::diff_t'($signed(f[sit_pkg::COORD_WIDTH-1:0]));
  endfunction

  function automatic logic in_range(input sit_pkg::diff_t v, input sit_pkg::diff_t e0,
                                    input sit_pkg::diff_t e1);
    return ((v >= e0) && (v <= e1)) || ((v >= e1) && (v <= e0));
  endfunction

  sit_pkg::diff_t  ax, ay, bx, by, cx, cy, dx, dy;
  sit_pkg::diffs_t q_nxt;

  always_comb begin
    ax = sext(a_x);
    ay = sext(a_y);
    bx = sext(b_x);
    by = sext(b_y);
    cx = sext(c_x);
    cy = sext(c_y);
    dx = sext(d_x);
    dy = sext(d_y);

    q_nxt.bax = bx - ax;
    q_nxt.bay = by - ay;
    q_nxt.cax = cx - ax;
    q_nxt.cay = cy - ay;
    q_nxt.dax = dx - ax;
    q_nxt.day = dy - ay;
    q_nxt.dcx = dx - cx;
    q_nxt.dcy = dy - cy;
    q_nxt.acx = ax - cx;
    q_nxt.acy = ay - cy;
    q_nxt.bcx = bx - cx;
    q_nxt.bcy = by - cy;

    q_nxt.box[0] = in_range(cx, ax, bx) && in_range(cy, ay, by);
    q_nxt.box[1] = in_range(dx, ax, bx) && in_range(dy, ay, by);
    q_nxt.box[2] = in_range(ax, cx, dx) && in_range(ay, cy, dy);
    q_nxt.box[3] = in_range(bx, cx, dx) && in_range(by, cy, dy);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

endmodule

@@ design/sit_mul.sv @@
`timescale 1ns / 1ps

module sit_mul (
  input  logic             clk,
  input  logic             en,
  input  sit_pkg::diffs_t  d,
  output sit_pkg::prods_t  q_r
);

  sit_pkg::prods_t q_nxt;

  // Eight independent exact products; each 33 by 33 bit multiply fits one stage.
  always_comb begin
    q_nxt.u1  = sit_pkg::prod_t'(d.bax) * sit_pkg::prod_t'(d.cay);
    q_nxt.v1  = sit_pkg::prod_t'(d.bay) * sit_pkg::prod_t'(d.cax);
    q_nxt.u2  = sit_pkg::prod_t'(d.bax) * sit_pkg::prod_t'(d.day);
    q_nxt.v2  = sit_pkg::prod_t'(d.bay) * sit_pkg::prod_t'(d.dax);
    q_nxt.u3  = sit_pkg::prod_t'(d.dcx) * sit_pkg::prod_t'(d.acy);
    q_nxt.v3  = sit_pkg::prod_t'(d.dcy) * sit_pkg::prod_t'(d.acx);
    q_nxt.u4  = sit_pkg::prod_t'(d.dcx) * sit_pkg::prod_t'(d.bcy);
    q_nxt.v4  = sit_pkg::prod_t'(d.dcy) * sit_pkg::prod_t'(d.bcx);
    q_nxt.box = d.box;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

endmodule

@@ design/sit_decide.sv @@
`timescale 1ns / 1ps

module sit_decide (
  input  logic              clk,
  input  sit_pkg::back_en_t en,
  input  sit_pkg::prods_t   p,
  output logic              meet_r
);

  function automatic sit_pkg::osign_t osign(input sit_pkg::prod_t u, input sit_pkg::prod_t v);
    sit_pkg::orient_t o;
    sit_pkg::osign_t  s;
    o      = sit_pkg::orient_t'(u) - sit_pkg::orient_t'(v);
    s.neg  = o[sit_pkg::ORIENT_W-1];
    s.zero = (o == '0);
    return s;
  endfunction

  sit_pkg::signs_t sg_r;
  sit_pkg::signs_t sg_nxt;
  logic            meet_nxt;

  always_comb begin
    sg_nxt.s1  = osign(p.u1, p.v1);
    sg_nxt.s2  = osign(p.u2, p.v2);
    sg_nxt.s3  = osign(p.u3, p.v3);
    sg_nxt.s4  = osign(p.u4, p.v4);
    sg_nxt.box = p.box;
  end

  // A zero orientation only counts when its point sits in the other segment's box.
  always_comb begin
    meet_nxt = ((sg_r.s1 != sg_r.s2) && (sg_r.s3 != sg_r.s4))
            || (sg_r.s1.zero && sg_r.box[0])
            || (sg_r.s2.zero && sg_r.box[1])
            || (sg_r.s3.zero && sg_r.box[2])
            || (sg_r.s4.zero && sg_r.box[3]);
  end

  always_ff @(posedge clk) begin
    if (en.sub) begin
      sg_r <= sg_nxt;
    end
    if (en.fin) begin
      meet_r <= meet_nxt;
    end
  end

endmodule

@@ design/segment_intersection_test.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Handshake     Word
// in_seg    in   valid/ready   a_x a_y b_x b_y c_x c_y d_x d_y (signed, 32 bits each)
// out_res   out  valid/ready   segments_meet (1 bit)
//
// One word enters per cycle unless a stall on out_res holds in_seg.ready low.
// The pipeline has four register stages: coordinate differences and box tests,
// the eight 33 by 33 bit products, the four orientation signs, and the final decision.
// rst_n is synchronous and active low; it clears the stage valid bits only.
// A stall on out_res holds each full stage, and bubbles ahead of a stall are filled.
module segment_intersection_test (
  input  logic      clk,
  input  logic      rst_n,
  sit_in_if.sink    in_seg,
  sit_out_if.source out_res
);

  // Valid bits of the four stages travel alongside the data registers.
  logic v1_r, v2_r, v3_r, v4_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt;

  // A stage may load when it is empty or when the stage after it moves on.
  logic rdy1, rdy2, rdy3, rdy4;

  sit_pkg::diffs_t   diffs;
  sit_pkg::prods_t   prods;
  sit_pkg::back_en_t back_en;

  always_comb begin
    rdy4 = !v4_r || out_res.ready;
    rdy3 = !v3_r || rdy4;
    rdy2 = !v2_r || rdy3;
    rdy1 = !v1_r || rdy2;

    v1_nxt = rdy1 ? in_seg.valid : v1_r;
    v2_nxt = rdy2 ? v1_r : v2_r;
    v3_nxt = rdy3 ? v2_r : v3_r;
    v4_nxt = rdy4 ? v3_r : v4_r;

    back_en.sub = rdy3;
    back_en.fin = rdy4;
  end

  assign in_seg.ready  = rdy1;
  assign out_res.valid = v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  // Stage one: sign extension, the twelve differences and the four box tests.
  sit_front u_front (
    .clk (clk),
    .en  (rdy1),
    .a_x (in_seg.a_x),
    .a_y (in_seg.a_y),
    .b_x (in_seg.b_x),
    .b_y (in_seg.b_y),
    .c_x (in_seg.c_x),
    .c_y (in_seg.c_y),
    .d_x (in_seg.d_x),
    .d_y (in_seg.d_y),
    .q_r (diffs)
  );

  // Stage two: the exact cross-product terms.
  sit_mul u_mul (
    .clk (clk),
    .en  (rdy2),
    .d   (diffs),
    .q_r (prods)
  );

  // Stages three and four: orientation signs, then the meeting rule.
  sit_decide u_decide (
    .clk    (clk),
    .en     (back_en),
    .p      (prods),
    .meet_r (out_res.segments_meet)
  );

endmodule

@@ design/sit_checker.sv @@
`timescale 1ns / 1ps

module sit_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input sit_pkg::field_t a_x,
  input sit_pkg::field_t a_y,
  input sit_pkg::field_t b_x,
  input sit_pkg::field_t b_y,
  input sit_pkg::field_t c_x,
  input sit_pkg::field_t c_y,
  input sit_pkg::field_t d_x,
  input sit_pkg::field_t d_y,
  input logic            out_valid,
  input logic            out_ready,
  input logic            segments_meet
);

  logic in_take;
  logic one_point;

  assign in_take   = in_valid && in_ready;
  assign one_point = (a_x == b_x) && (a_x == c_x) && (a_x == d_x)
                  && (a_y == b_y) && (a_y == c_y) && (a_y == d_y);

  // Nothing is left in the pipeline right after reset.
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // Four coincident points always meet; with out_ready held high their verdict is not held back by a stall.
  a_point_meets: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && one_point) ##1 out_ready ##1 out_ready ##1 out_ready
      |=> (out_valid && segments_meet))
    else $error("coincident points not reported as meeting on time");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(segments_meet))
    else $error("result changed while stalled");

endmodule

bind segment_intersection_test sit_checker u_sit_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_seg.valid),
  .in_ready      (in_seg.ready),
  .a_x           (in_seg.a_x),
  .a_y           (in_seg.a_y),
  .b_x           (in_seg.b_x),
  .b_y           (in_seg.b_y),
  .c_x           (in_seg.c_x),
  .c_y           (in_seg.c_y),
  .d_x           (in_seg.d_x),
  .d_y           (in_seg.d_y),
  .out_valid     (out_res.valid),
  .out_ready     (out_res.ready),
  .segments_meet (out_res.segments_meet)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  // Coordinates after sign extension from COORD_WIDTH bits.
  localparam longint CMIN = -(longint'(1) << (sit_pkg::COORD_WIDTH - 1));
  localparam longint CMAX = (longint'(1) << (sit_pkg::COORD_WIDTH - 1)) - 1;

  // Random words are pushed in phases; each phase uses its own idle mix.
  localparam int PHASES     = 6;
  localparam int PHASE_LEN  = 75;
  // Longest correct quiet stretch is a sender gap plus a receiver stall plus
  // the four pipeline stages, well below STALL_LIMIT.
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;

  // The orientation products need 67 signed bits; two spare bits are kept.
  typedef logic signed [sit_pkg::ORIENT_W+1:0] wide_t;

  typedef struct packed {
    sit_pkg::field_t ax;
    sit_pkg::field_t ay;
    sit_pkg::field_t bx;
    sit_pkg::field_t by;
    sit_pkg::field_t cx;
    sit_pkg::field_t cy;
    sit_pkg::field_t dx;
    sit_pkg::field_t dy;
  } seg_pair_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  sit_in_if  in_seg ();
  sit_out_if out_res ();

  segment_intersection_test DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_seg (in_seg),
    .out_res(out_res)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Words waiting to be driven, and the verdicts owed by the block in order.
  seg_pair_t pending_pairs[$];
  bit        meet_expected[$];

  // Idle limits for the current phase, set by the stimulus block.
  int send_gap_max = 0;
  int stall_max    = 0;

  int  send_gap_left = 0;
  int  stall_left    = 0;
  bit  in_took       = 1'b0;
  bit  out_took      = 1'b0;
  int  idle_cycles   = 0;
  int  fail_count    = 0;
  int  words_sent    = 0;
  int  results_seen  = 0;
  int  meets_seen    = 0;
  seg_pair_t next_pair;

  // ---------------------------------------------------------------------------
  // Predictor. A coordinate is the sign-extended low COORD_WIDTH bits of its
  // field. The orientation of R against the line P->Q is the sign of
  // (Qx-Px)*(Ry-Py) - (Qy-Py)*(Rx-Px), formed exactly in wide integers.
  // ---------------------------------------------------------------------------
  function automatic longint coord_of(sit_pkg::field_t f);
    logic signed [sit_pkg::COORD_WIDTH-1:0] c;
    c = f[sit_pkg::COORD_WIDTH-1:0];
    return c;
  endfunction

  function automatic int orient_sign(longint px, longint py, longint qx, longint qy,
                                     longint rx, longint ry);
    wide_t dqx, dqy, drx, dry, lhs, rhs;
    dqx = wide_t'(qx) - wide_t'(px);
    dqy = wide_t'(qy) - wide_t'(py);
    drx = wide_t'(rx) - wide_t'(px);
    dry = wide_t'(ry) - wide_t'(py);
    lhs = dqx * dry;
    rhs = dqy * drx;
    if (lhs < rhs) return -1;
    if (lhs > rhs) return 1;
    return 0;
  endfunction

  function automatic bit in_span(longint v, longint e0, longint e1);
    return v >= (e0 < e1 ? e0 : e1) && v <= (e0 > e1 ? e0 : e1);
  endfunction

  function automatic bit predict_meet(seg_pair_t w);
    longint ax, ay, bx, by, cx, cy, dx, dy;
    int s1, s2, s3, s4;
    ax = coord_of(w.ax);
    ay = coord_of(w.ay);
    bx = coord_of(w.bx);
    by = coord_of(w.by);
    cx = coord_of(w.cx);
    cy = coord_of(w.cy);
    dx = coord_of(w.dx);
    dy = coord_of(w.dy);
    s1 = orient_sign(ax, ay, bx, by, cx, cy);
    s2 = orient_sign(ax, ay, bx, by, dx, dy);
    s3 = orient_sign(cx, cy, dx, dy, ax, ay);
    s4 = orient_sign(cx, cy, dx, dy, bx, by);
    // A proper crossing splits both pairs; otherwise a point lying on the
    // line of the other segment must also fall inside its bounding box.
    return (s1 != s2 && s3 != s4)
        || (s1 == 0 && in_span(cx, ax, bx) && in_span(cy, ay, by))
        || (s2 == 0 && in_span(dx, ax, bx) && in_span(dy, ay, by))
        || (s3 == 0 && in_span(ax, cx, dx) && in_span(ay, cy, dy))
        || (s4 == 0 && in_span(bx, cx, dx) && in_span(by, cy, dy));
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic push_pair(longint ax, longint ay, longint bx, longint by,
                           longint cx, longint cy, longint dx, longint dy);
    seg_pair_t w;
    w.ax = sit_pkg::field_t'(ax);
    w.ay = sit_pkg::field_t'(ay);
    w.bx = sit_pkg::field_t'(bx);
    w.by = sit_pkg::field_t'(by);
    w.cx = sit_pkg::field_t'(cx);
    w.cy = sit_pkg::field_t'(cy);
    w.dx = sit_pkg::field_t'(dx);
    w.dy = sit_pkg::field_t'(dy);
    pending_pairs.push_back(w);
  endtask

  // An anchor point for small shapes; the ends of the range are favored so
  // that the exact products are exercised at full magnitude.
  function automatic longint pick_base();
    case ($urandom_range(0, 3))
      0:       return CMIN + 20;
      1:       return CMAX - 20;
      2:       return int'($urandom) >>> 12;
      default: return int'($urandom);
    endcase
  endfunction

  // Most random words are built to land on the interesting boundaries:
  // small grids, collinear sets, and one endpoint placed exactly on the
  // other segment. The rest are fully random or made of extreme values.
  task automatic push_random_pair();
    longint pt[8];
    longint px, py, ux, uy, k, span, tmp;
    int pick;
    pick = $urandom_range(0, 99);
    px = pick_base();
    py = pick_base();
    ux = $urandom_range(0, 6);
    uy = $urandom_range(0, 6);
    ux -= 3;
    uy -= 3;
    if (pick < 20) begin
      foreach (pt[j]) pt[j] = int'($urandom);
    end else if (pick < 45) begin
      for (int j = 0; j < 8; j += 2) begin
        pt[j]   = px + $urandom_range(0, 7);
        pt[j+1] = py + $urandom_range(0, 7);
      end
    end else if (pick < 65) begin
      for (int j = 0; j < 8; j += 2) begin
        k = $urandom_range(0, 8);
        k -= 4;
        pt[j]   = px + k * ux;
        pt[j+1] = py + k * uy;
      end
    end else if (pick < 85) begin
      span = $urandom_range(1, 4);
      k    = $urandom_range(0, span);
      pt[0] = px;
      pt[1] = py;
      pt[2] = px + span * ux;
      pt[3] = py + span * uy;
      pt[4] = px + k * ux;
      pt[5] = py + k * uy;
      pt[6] = pt[4] + $urandom_range(0, 10) - 5;
      pt[7] = pt[5] + $urandom_range(0, 10) - 5;
      // Randomly move the touching point to D, and randomly swap the two segments.
      if ($urandom_range(0, 1)) begin
        tmp = pt[4]; pt[4] = pt[6]; pt[6] = tmp;
        tmp = pt[5]; pt[5] = pt[7]; pt[7] = tmp;
      end
      if ($urandom_range(0, 1)) begin
        for (int j = 0; j < 4; j++) begin
          tmp = pt[j]; pt[j] = pt[j+4]; pt[j+4] = tmp;
        end
      end
    end else begin
      foreach (pt[j]) begin
        case ($urandom_range(0, 5))
          0:       pt[j] = CMIN;
          1:       pt[j] = CMAX;
          2:       pt[j] = 0;
          3:       pt[j] = -1;
          4:       pt[j] = 1;
          default: pt[j] = int'($urandom);
        endcase
      end
    end
    push_pair(pt[0], pt[1], pt[2], pt[3], pt[4], pt[5], pt[6], pt[7]);
  endtask

  // The sender holds back until every queued word is out and every verdict
  // has come back. This is checked at the rising edge, where the driver's
  // outputs are settled.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_pairs.size() != 0 || in_seg.valid || meet_expected.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Driver. Changes happen on the falling edge. After each word is taken a
  // random gap, bounded by send_gap_max, is drawn before the next one is shown.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_seg.valid <= 1'b0;
      send_gap_left = 0;
    end else if (!in_seg.valid || in_took) begin
      if (in_took) send_gap_left = $urandom_range(0, send_gap_max);
      if (send_gap_left > 0 || pending_pairs.size() == 0) begin
        if (send_gap_left > 0) send_gap_left--;
        in_seg.valid <= 1'b0;
      end else begin
        next_pair = pending_pairs.pop_front();
        in_seg.a_x   <= next_pair.ax;
        in_seg.a_y   <= next_pair.ay;
        in_seg.b_x   <= next_pair.bx;
        in_seg.b_y   <= next_pair.by;
        in_seg.c_x   <= next_pair.cx;
        in_seg.c_y   <= next_pair.cy;
        in_seg.d_x   <= next_pair.dx;
        in_seg.d_y   <= next_pair.dy;
        in_seg.valid <= 1'b1;
      end
    end
  end

  // Result side backpressure: after each word taken, ready drops for a drawn
  // number of cycles and then stays high until the next word is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_res.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_took) stall_left = $urandom_range(0, stall_max);
      if (stall_left > 0) begin
        stall_left--;
        out_res.ready <= 1'b0;
      end else begin
        out_res.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor and scoreboard, sampled at the rising edge. Each accepted input
  // word adds its verdict to the queue; each accepted result is compared
  // with the oldest one. A watchdog ends the run when no word has moved and its
  // idle count reaches STALL_LIMIT.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took     <= 1'b0;
      out_took    <= 1'b0;
      idle_cycles = 0;
    end else begin
      in_took  <= in_seg.valid && in_seg.ready;
      out_took <= out_res.valid && out_res.ready;
      if (in_seg.valid && in_seg.ready) begin
        meet_expected.push_back(predict_meet({in_seg.a_x, in_seg.a_y, in_seg.b_x, in_seg.b_y,
                                              in_seg.c_x, in_seg.c_y, in_seg.d_x,
                                              in_seg.d_y}));
        words_sent++;
      end
      if (out_res.valid && out_res.ready) begin
        results_seen++;
        if (meet_expected.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result word, expected none, got segments_meet=%0b",
                   $time, out_res.segments_meet);
        end else begin
          if (meet_expected[0]) meets_seen++;
          if (out_res.segments_meet !== meet_expected[0]) begin
            fail_count++;
            $display("%0t: segments_meet mismatch, expected %0b, got %0b",
                     $time, meet_expected[0], out_res.segments_meet);
          end
          void'(meet_expected.pop_front());
        end
      end
      if ((in_seg.valid && in_seg.ready) || (out_res.valid && out_res.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles == STALL_LIMIT) begin
        $display("%0t: timeout, no word moved for %0d cycles, %0d verdicts outstanding",
                 $time, STALL_LIMIT, meet_expected.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence.
  // ---------------------------------------------------------------------------
  initial begin
    in_seg.valid  = 1'b0;
    in_seg.a_x    = '0;
    in_seg.a_y    = '0;
    in_seg.b_x    = '0;
    in_seg.b_y    = '0;
    in_seg.c_x    = '0;
    in_seg.c_y    = '0;
    in_seg.d_x    = '0;
    in_seg.d_y    = '0;
    out_res.ready = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words with light idling on both sides.
    send_gap_max = 2;
    stall_max    = 2;
    push_pair(0, 0, 10, 10, 0, 10, 10, 0);          // plain X crossing
    push_pair(0, 0, 10, 0, 0, 1, 10, 1);            // parallel, apart
    push_pair(0, 0, 10, 0, 5, 0, 5, 7);             // T: C lies inside AB
    push_pair(0, 0, 10, 0, 5, -3, 5, -1);           // T that stops short
    push_pair(0, 0, 4, 4, 4, 4, 9, 0);              // shared endpoint B = C
    push_pair(0, 0, 10, 0, 6, 0, 15, 0);            // collinear, overlapping
    push_pair(0, 0, 10, 0, 11, 0, 20, 0);           // collinear, with a gap
    push_pair(0, 0, 0, 10, 0, 10, 0, 20);           // vertical, end to end
    push_pair(0, 0, 10, 0, 3, 0, 3, 0);             // point on AB
    push_pair(0, 0, 10, 0, 3, 1, 3, 1);             // point just off AB
    push_pair(7, -2, 7, -2, 7, -2, 7, -2);          // two equal points
    push_pair(7, -2, 7, -2, -7, 2, -7, 2);          // two distinct points
    push_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN);
    push_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMIN + 1, CMAX - 1, CMAX);
    push_pair(CMIN, CMIN, CMAX, CMAX - 1, CMAX, CMAX, CMIN + 1, CMIN);
    push_pair(CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN);
    push_pair(CMAX, 0, CMIN, 0, 0, CMAX, 0, CMIN);  // the two axes
    push_pair(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    push_pair(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
    push_pair(-1, -1, -1, -1, -1, -1, -1, -1);
    push_pair(0, 0, 0, 0, 0, 0, 0, 0);
    push_pair(int'(32'hAAAAAAAA), int'(32'h55555555), int'(32'h55555555),
              int'(32'hAAAAAAAA), int'(32'hAAAAAAAA), int'(32'hAAAAAAAA),
              int'(32'h55555555), int'(32'h55555555));
    // The sender pauses here until every verdict is back.
    wait_drained();

    // Random phases. The idle mix cycles through no idling, sender gaps,
    // receiver stalls and both; the pipeline drains between phases.
    for (int phase_idx = 0; phase_idx < PHASES; phase_idx++) begin
      send_gap_max = (phase_idx % 2 == 1) ? 19 : 0;
      stall_max    = ((phase_idx / 2) % 2 == 1) ? 19 : 0;
      for (int n = 0; n < PHASE_LEN; n++) push_random_pair();
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d segment pairs (%0d meeting, %0d apart), %0d mismatches.",
             results_seen, meets_seen, results_seen - meets_seen, fail_count);
    $display("Stimulus: corner cases, crossings, touches, collinear and extreme pairs.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
